// ===== rtl/st4_pkg.sv =====
// Shared types and constants for the clocked serial master.
// No dependencies; the three design modules import this package.
package st4_pkg;

    // Phase counter: counts down from the idle value through one frame
    localparam logic [4:0] PHASE_IDLE   = 5'd24;
    localparam logic [4:0] PH_START_TX  = 5'd23;
    localparam logic [4:0] PH_START_RX  = 5'd22;
    localparam logic [4:0] PH_DATA_LAST = 5'd6;
    localparam logic [4:0] PH_PAR_TX    = 5'd5;
    localparam logic [4:0] PH_PAR_RX    = 5'd4;
    localparam logic [4:0] PH_CHK_TX    = 5'd3;
    localparam logic [4:0] PH_CHK_RX    = 5'd2;
    localparam logic [4:0] PH_STOP_TX   = 5'd1;
    localparam logic [4:0] PH_STOP_RX   = 5'd0;

    // Received bytes below this are control characters
    localparam logic [7:0] CONTROL_LIMIT = 8'd32;

    // Configuration register file
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HOLDOFF = 2'd0,
        CFG_STOP_HOLDOFF  = 2'd1
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] START_HOLDOFF_RST = 12'd1001;
    localparam logic [CFG_DATA_W-1:0] STOP_HOLDOFF_RST  = 12'd12;

    // One result beat
    typedef struct packed {
        logic       clock_level;
        logic       line_out_level;
        logic       tx_taken;
        logic       byte_done;
        logic [7:0] rx_byte;
        logic       rx_control;
        logic       rx_parity_error;
        logic       tx_parity_error;
        logic       frame_abort;
        logic       holding;
    } result_t;

endpackage

// ===== rtl/st4_if.sv =====
// Valid/ready channel interfaces for tick beats in and result beats out.
// No dependencies.
interface st4_tick_if;
    logic       valid;
    logic       ready;
    logic       line_in_level;
    logic       ms_strobe;
    logic       tx_valid;
    logic [7:0] tx_byte;

    modport source (output valid, line_in_level, ms_strobe, tx_valid, tx_byte,
                    input ready);
    modport sink   (input valid, line_in_level, ms_strobe, tx_valid, tx_byte,
                    output ready);
endinterface

interface st4_result_if;
    logic       valid;
    logic       ready;
    logic       clock_level;
    logic       line_out_level;
    logic       tx_taken;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       rx_control;
    logic       rx_parity_error;
    logic       tx_parity_error;
    logic       frame_abort;
    logic       holding;

    modport source (output valid, clock_level, line_out_level, tx_taken, byte_done,
                    rx_byte, rx_control, rx_parity_error, tx_parity_error,
                    frame_abort, holding,
                    input ready);
    modport sink   (input valid, clock_level, line_out_level, tx_taken, byte_done,
                    rx_byte, rx_control, rx_parity_error, tx_parity_error,
                    frame_abort, holding,
                    output ready);
endinterface

// ===== rtl/st4_sync_serial_master.sv =====
// Top level of the clocked full-duplex serial master.
// Depends on st4_pkg, st4_if, st4_frame_seq and st4_out_stage.
//
// Each tick beat is one half-bit phase of the serial link; a frame is 24
// phases (start, eight data bits each way MSB first, even parity, parity
// check exchange, stop). Every accepted tick yields exactly one result beat,
// which is loaded into the result register when the tick is accepted. A tick
// can be taken every clock cycle: the phase logic is a single pass between
// the state registers and the result register, and tick.ready drops only
// while the result register is full and the sink is not taking it. The user
// must write both holdoff registers (cfg_we/cfg_index/cfg_data) only while
// no tick is in flight (not enforced); writes to other indexes are ignored.
module st4_sync_serial_master
    import st4_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    st4_tick_if.sink              tick,
    st4_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] start_holdoff_reg;
    logic [CFG_DATA_W-1:0] stop_holdoff_reg;
    logic                  can_load;
    logic                  accept;
    result_t               step_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_holdoff_reg <= START_HOLDOFF_RST;
            stop_holdoff_reg  <= STOP_HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_HOLDOFF: start_holdoff_reg <= cfg_data;
                CFG_STOP_HOLDOFF:  stop_holdoff_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Tick handshake
    assign tick.ready = can_load;
    assign accept     = tick.valid && can_load;

    st4_frame_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .line_in_level (tick.line_in_level),
        .ms_strobe     (tick.ms_strobe),
        .tx_valid      (tick.tx_valid),
        .tx_byte       (tick.tx_byte),
        .start_holdoff (start_holdoff_reg),
        .stop_holdoff  (stop_holdoff_reg),
        .res           (step_res)
    );

    st4_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res_in   (step_res),
        .can_load (can_load),
        .result   (result)
    );

endmodule

// ===== rtl/st4_frame_seq.sv =====
// Frame sequencer: phase counter, shift registers, parity and holdoff state.
// Depends on st4_pkg. State advances only on an accepted tick beat.
module st4_frame_seq
    import st4_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  line_in_level,
    input  logic                  ms_strobe,
    input  logic                  tx_valid,
    input  logic [7:0]            tx_byte,
    input  logic [CFG_DATA_W-1:0] start_holdoff,
    input  logic [CFG_DATA_W-1:0] stop_holdoff,
    output result_t               res
);

    logic [4:0]            phase_reg, phase_next;
    logic [7:0]            tx_shift_reg, tx_shift_next;
    logic [7:0]            rx_shift_reg, rx_shift_next;
    logic                  tx_par_reg, tx_par_next;
    logic                  rx_par_reg, rx_par_next;
    logic                  rx_err_reg, rx_err_next;
    logic                  tx_err_reg, tx_err_next;
    logic                  frm_err_reg, frm_err_next;
    logic [CFG_DATA_W-1:0] hold_cnt_reg, hold_cnt_next;
    logic                  hold_reg, hold_next;
    logic                  clk_out_reg, clk_out_next;
    logic                  line_out_reg, line_out_next;

    logic                  run;
    logic [4:0]            phase_cur;
    logic [4:0]            p;
    logic [4:0]            data_off;
    logic [2:0]            bitpos;
    logic [CFG_DATA_W-1:0] cnt_dec;
    logic                  stop_bad;

    // Next state and result for one tick
    always_comb
    begin
        phase_next    = phase_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        tx_par_next   = tx_par_reg;
        rx_par_next   = rx_par_reg;
        rx_err_next   = rx_err_reg;
        tx_err_next   = tx_err_reg;
        frm_err_next  = frm_err_reg;
        hold_cnt_next = hold_cnt_reg;
        hold_next     = hold_reg;
        clk_out_next  = clk_out_reg;
        line_out_next = line_out_reg;
        res           = '0;
        run           = 1'b1;
        phase_cur     = phase_reg;
        cnt_dec       = hold_cnt_reg;
        p             = '0;
        data_off      = '0;
        bitpos        = '0;
        stop_bad      = 1'b0;

        // Holdoff countdown; release runs the start phase in the same tick
        if (hold_reg)
        begin
            if (ms_strobe && (hold_cnt_reg != '0))
                cnt_dec = hold_cnt_reg - 1'b1;
            hold_cnt_next = cnt_dec;
            if (cnt_dec == '0)
            begin
                hold_next = 1'b0;
                phase_cur = PHASE_IDLE;
            end
            else
                run = 1'b0;
        end

        if (run)
        begin
            if ((phase_cur == '0) || (phase_cur > PHASE_IDLE))
                p = PHASE_IDLE - 5'd1;
            else
                p = phase_cur - 5'd1;
            phase_next = p;
            data_off   = p - PH_DATA_LAST;
            bitpos     = data_off[3:1];

            case (p)
                PH_START_TX:
                begin
                    if (!tx_err_reg)
                    begin
                        tx_shift_next = tx_valid ? tx_byte : 8'd0;
                        res.tx_taken  = tx_valid;
                    end
                    tx_par_next   = 1'b0;
                    rx_par_next   = 1'b0;
                    frm_err_next  = 1'b0;
                    tx_err_next   = 1'b0;
                    rx_err_next   = 1'b0;
                    clk_out_next  = 1'b0;
                    line_out_next = 1'b0;
                end
                PH_START_RX:
                begin
                    clk_out_next = 1'b1;
                    if (line_in_level)
                    begin
                        frm_err_next    = 1'b1;
                        hold_cnt_next   = start_holdoff;
                        hold_next       = 1'b1;
                        res.frame_abort = 1'b1;
                    end
                end
                PH_PAR_TX:
                begin
                    clk_out_next  = 1'b0;
                    line_out_next = tx_par_reg;
                end
                PH_PAR_RX:
                begin
                    clk_out_next = 1'b1;
                    if (rx_par_reg != line_in_level)
                        rx_err_next = 1'b1;
                end
                PH_CHK_TX:
                begin
                    clk_out_next  = 1'b0;
                    line_out_next = rx_err_reg;
                end
                PH_CHK_RX:
                begin
                    clk_out_next = 1'b1;
                    if (line_in_level)
                        tx_err_next = 1'b1;
                end
                PH_STOP_TX:
                begin
                    clk_out_next  = 1'b0;
                    line_out_next = 1'b0;
                end
                PH_STOP_RX:
                begin
                    clk_out_next = 1'b1;
                    stop_bad     = frm_err_reg | line_in_level;
                    frm_err_next = stop_bad;
                    if (stop_bad)
                    begin
                        hold_cnt_next   = stop_holdoff;
                        hold_next       = 1'b1;
                        res.frame_abort = 1'b1;
                    end
                    else
                    begin
                        res.byte_done       = 1'b1;
                        res.rx_byte         = rx_shift_reg;
                        res.rx_control      = (rx_shift_reg < CONTROL_LIMIT);
                        res.rx_parity_error = rx_err_reg;
                        res.tx_parity_error = tx_err_reg;
                    end
                    phase_next = PHASE_IDLE;
                end
                default:
                begin
                    // Data bits, MSB first: odd phase drives, even phase samples
                    if (p[0])
                    begin
                        tx_par_next   = tx_par_reg ^ tx_shift_reg[bitpos];
                        clk_out_next  = 1'b0;
                        line_out_next = tx_shift_reg[bitpos];
                    end
                    else
                    begin
                        clk_out_next          = 1'b1;
                        rx_par_next           = rx_par_reg ^ line_in_level;
                        rx_shift_next[bitpos] = line_in_level;
                    end
                end
            endcase
        end

        res.clock_level    = clk_out_next;
        res.line_out_level = line_out_next;
        res.holding        = hold_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_IDLE;
            tx_shift_reg <= '0;
            rx_shift_reg <= '0;
            tx_par_reg   <= 1'b0;
            rx_par_reg   <= 1'b0;
            rx_err_reg   <= 1'b0;
            tx_err_reg   <= 1'b0;
            frm_err_reg  <= 1'b0;
            hold_cnt_reg <= '0;
            hold_reg     <= 1'b0;
            clk_out_reg  <= 1'b0;
            line_out_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            tx_par_reg   <= tx_par_next;
            rx_par_reg   <= rx_par_next;
            rx_err_reg   <= rx_err_next;
            tx_err_reg   <= tx_err_next;
            frm_err_reg  <= frm_err_next;
            hold_cnt_reg <= hold_cnt_next;
            hold_reg     <= hold_next;
            clk_out_reg  <= clk_out_next;
            line_out_reg <= line_out_next;
        end
    end

endmodule

// ===== rtl/st4_out_stage.sv =====
// Result register: holds one result beat until the sink takes it.
// Depends on st4_pkg and st4_result_if.
module st4_out_stage
    import st4_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             res_in,
    output logic                can_load,
    st4_result_if.source        result
);

    logic    valid_reg;
    result_t data_reg;

    // Free when empty or when the held beat leaves this cycle
    assign can_load = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign result.valid           = valid_reg;
    assign result.clock_level     = data_reg.clock_level;
    assign result.line_out_level  = data_reg.line_out_level;
    assign result.tx_taken        = data_reg.tx_taken;
    assign result.byte_done       = data_reg.byte_done;
    assign result.rx_byte         = data_reg.rx_byte;
    assign result.rx_control      = data_reg.rx_control;
    assign result.rx_parity_error = data_reg.rx_parity_error;
    assign result.tx_parity_error = data_reg.tx_parity_error;
    assign result.frame_abort     = data_reg.frame_abort;
    assign result.holding         = data_reg.holding;

endmodule
